@@ rtl/htfe_pkg.sv @@
// Package for the header/trailer frame extractor.
// Holds field widths, framing constants, FSM state type and the
// command/status structs shared by controller and datapath.
package htfe_pkg;

   localparam int BYTE_W        = 8;
   localparam int LEN_REG_W     = 5;
   localparam int CLAMP_W       = 7;
   localparam int MAX_FRAME_DEF = 16;
   localparam int MIN_FRAME     = 5;

   localparam logic [LEN_REG_W-1:0] FRAME_LEN_RESET = 5'd16;

   localparam logic [BYTE_W-1:0] HDR0 = 8'h24;
   localparam logic [BYTE_W-1:0] HDR1 = 8'h03;
   localparam logic [BYTE_W-1:0] TRL0 = 8'h0D;
   localparam logic [BYTE_W-1:0] TRL1 = 8'h0A;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_EMIT,
      ST_TRAIL
   } state_type;

   typedef struct packed {
      logic append;
      logic shift1;
      logic shift2;
      logic load_cnt;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic fill_ge_len;
      logic fill_zero;
      logic hdr_front;
      logic trl_ok;
      logic cnt_last;
      logic out_free;
   } sts_type;

endpackage

@@ rtl/htfe_req_if.sv @@
// Stream interfaces for the frame extractor: received bytes, payload
// results and the frame length write channel. Uses htfe_pkg widths.
interface htfe_req_if;
   logic                          valid;
   logic                          ready;
   logic [htfe_pkg::BYTE_W-1:0]   rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface htfe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [htfe_pkg::BYTE_W-1:0]   payload_byte;
   logic                          last_of_frame;
   modport source (output valid, output payload_byte, output last_of_frame, input ready);
   modport sink   (input valid, input payload_byte, input last_of_frame, output ready);
endinterface

interface htfe_csr_if;
   logic                           valid;
   logic                           ready;
   logic [htfe_pkg::LEN_REG_W-1:0] frame_len;
   modport source (output valid, output frame_len, input ready);
   modport sink   (input valid, input frame_len, output ready);
endinterface

@@ rtl/header_trailer_frame_extractor.sv @@
// Fixed-length frame extractor: bytes arrive one request at a time into a
// window of MAX_FRAME bytes; frames of frame_len bytes (clamped to 5..MAX_FRAME)
// starting with 0x24 0x03 and ending in CR LF release their payload bytes in
// order, the last one flagged. A request is taken only while the controller is
// idle. Each request is appended and then checked; a header search then drops
// one window byte per cycle, and a valid frame has its header removed, then
// releases its payload bytes (stalling while a held result is not yet taken),
// then has its trailer removed. Results wait in an output register. Depends
// on htfe_pkg, the htfe interfaces, htfe_ctrl and htfe_dp.
module header_trailer_frame_extractor #(
   parameter int MAX_FRAME = htfe_pkg::MAX_FRAME_DEF
) (
   input  logic       clock,
   input  logic       reset,
   htfe_req_if.sink   req_port,
   htfe_rsp_if.source rsp_port,
   htfe_csr_if.sink   csr_port
);

   htfe_pkg::cmd_type cmd;
   htfe_pkg::sts_type sts;
   logic              req_ready;

   assign req_port.ready = req_ready;
   assign csr_port.ready = 1'b1;

   htfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   htfe_dp #(
      .MAX_FRAME (MAX_FRAME)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .rx_byte           (req_port.rx_byte),
      .csr_we            (csr_port.valid),
      .csr_frame_len     (csr_port.frame_len),
      .rsp_valid         (rsp_port.valid),
      .rsp_ready         (rsp_port.ready),
      .rsp_payload_byte  (rsp_port.payload_byte),
      .rsp_last_of_frame (rsp_port.last_of_frame)
   );

endmodule

@@ rtl/htfe_ctrl.sv @@
// Controller FSM for the frame extractor.
// Drives datapath commands from datapath status; depends on htfe_pkg.
module htfe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  htfe_pkg::sts_type   sts,
   output htfe_pkg::cmd_type   cmd
);

   htfe_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= htfe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         htfe_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = htfe_pkg::ST_CHECK;
            end
         end
         htfe_pkg::ST_CHECK: begin
            priority if (!sts.fill_ge_len) begin
               state_in = htfe_pkg::ST_IDLE;
            end else if (sts.hdr_front && sts.trl_ok) begin
               state_in = htfe_pkg::ST_EMIT;
            end else if (sts.hdr_front) begin
               // bad trailer: drop the header start, then recheck the fill
               state_in = htfe_pkg::ST_CHECK;
            end else begin
               state_in = htfe_pkg::ST_SCAN;
            end
         end
         htfe_pkg::ST_SCAN: begin
            if (sts.fill_zero || sts.hdr_front) begin
               state_in = htfe_pkg::ST_CHECK;
            end
         end
         htfe_pkg::ST_EMIT: begin
            if (sts.out_free && sts.cnt_last) begin
               state_in = htfe_pkg::ST_TRAIL;
            end
         end
         htfe_pkg::ST_TRAIL: begin
            state_in = htfe_pkg::ST_CHECK;
         end
         default: begin
            state_in = htfe_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         htfe_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.append = req_valid;
         end
         htfe_pkg::ST_CHECK: begin
            if (sts.fill_ge_len) begin
               if (sts.hdr_front && sts.trl_ok) begin
                  cmd.shift2   = 1'b1;
                  cmd.load_cnt = 1'b1;
               end else begin
                  cmd.shift1 = 1'b1;
               end
            end
         end
         htfe_pkg::ST_SCAN: begin
            if (!sts.fill_zero && !sts.hdr_front) begin
               cmd.shift1 = 1'b1;
            end
         end
         htfe_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit   = 1'b1;
               cmd.shift1 = 1'b1;
            end
         end
         htfe_pkg::ST_TRAIL: begin
            cmd.shift2 = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/htfe_dp.sv @@
// Datapath for the frame extractor: byte window shift line, fill count,
// frame length register, payload counter and result register. Uses htfe_pkg.
module htfe_dp #(
   parameter int MAX_FRAME = htfe_pkg::MAX_FRAME_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  htfe_pkg::cmd_type              cmd,
   output htfe_pkg::sts_type              sts,
   input  logic [htfe_pkg::BYTE_W-1:0]    rx_byte,
   input  logic                           csr_we,
   input  logic [htfe_pkg::LEN_REG_W-1:0] csr_frame_len,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [htfe_pkg::BYTE_W-1:0]    rsp_payload_byte,
   output logic                           rsp_last_of_frame
);

   localparam int FW = $clog2(MAX_FRAME + 1);
   localparam int LW = FW;
   localparam int PW = $clog2(MAX_FRAME - 1);
   localparam int CW = $clog2(MAX_FRAME - 3);

   logic [htfe_pkg::BYTE_W-1:0] win_ff [MAX_FRAME];
   logic [htfe_pkg::BYTE_W-1:0] win_in [MAX_FRAME];
   logic [FW-1:0]               fill_ff, fill_in;
   logic [htfe_pkg::LEN_REG_W-1:0] flen_ff;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic                        out_valid_ff, out_valid_in;
   logic [htfe_pkg::BYTE_W-1:0] out_data_ff, out_data_in;
   logic                        out_last_ff, out_last_in;

   logic [htfe_pkg::CLAMP_W-1:0] flen_wide;
   logic [LW-1:0]                len;
   logic [PW-1:0]                trl_idx;
   logic [MAX_FRAME-2:0]         pair_ok;
   logic                         full;

   always_comb begin
      flen_wide = htfe_pkg::CLAMP_W'(flen_ff);
      priority if (flen_wide < htfe_pkg::CLAMP_W'(htfe_pkg::MIN_FRAME)) begin
         len = LW'(htfe_pkg::MIN_FRAME);
      end else if (flen_wide > htfe_pkg::CLAMP_W'(MAX_FRAME)) begin
         len = LW'(MAX_FRAME);
      end else begin
         len = LW'(flen_wide);
      end
   end

   // trailer flags at every pair position, picked by frame length
   always_comb begin
      for (int k = 0; k < MAX_FRAME - 1; k++) begin
         pair_ok[k] = (win_ff[k] == htfe_pkg::TRL0) && (win_ff[k+1] == htfe_pkg::TRL1);
      end
   end

   assign trl_idx = PW'(len - LW'(2));
   assign full    = (fill_ff == FW'(MAX_FRAME));

   always_comb begin
      sts.fill_ge_len = (fill_ff >= len);
      sts.fill_zero   = (fill_ff == '0);
      sts.hdr_front   = (fill_ff >= FW'(2)) && (win_ff[0] == htfe_pkg::HDR0)
                        && (win_ff[1] == htfe_pkg::HDR1);
      sts.trl_ok      = pair_ok[trl_idx];
      sts.cnt_last    = (cnt_ff == CW'(1));
      sts.out_free    = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      fill_in = fill_ff;
      for (int k = 0; k < MAX_FRAME; k++) begin
         win_in[k] = win_ff[k];
      end
      if (cmd.append) begin
         for (int k = 0; k < MAX_FRAME; k++) begin
            if (full) begin
               if (k == MAX_FRAME - 1) begin
                  win_in[k] = rx_byte;
               end else begin
                  win_in[k] = win_ff[k+1];
               end
            end else if (FW'(k) == fill_ff) begin
               win_in[k] = rx_byte;
            end
         end
         if (!full) begin
            fill_in = fill_ff + FW'(1);
         end
      end else if (cmd.shift2) begin
         for (int k = 0; k < MAX_FRAME - 2; k++) begin
            win_in[k] = win_ff[k+2];
         end
         fill_in = (fill_ff >= FW'(2)) ? fill_ff - FW'(2) : '0;
      end else if (cmd.shift1) begin
         for (int k = 0; k < MAX_FRAME - 1; k++) begin
            win_in[k] = win_ff[k+1];
         end
         fill_in = (fill_ff != '0) ? fill_ff - FW'(1) : '0;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load_cnt) begin
         cnt_in = CW'(len - LW'(4));
      end else if (cmd.emit) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_data_in  = win_ff[0];
         out_last_in  = sts.cnt_last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_FRAME; k++) begin
         win_ff[k] <= win_in[k];
      end
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      cnt_ff      <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         flen_ff      <= htfe_pkg::FRAME_LEN_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            flen_ff <= csr_frame_len;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_byte  = out_data_ff;
   assign rsp_last_of_frame = out_last_ff;

endmodule
